// ===== rtl/odo_pkg.sv =====
// ----------------------------------------------------------------------------
// odo_pkg
// shared types, widths and arithmetic helpers for the wheel odometry block
// ----------------------------------------------------------------------------
package odo_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int CI_W = 5;            // cordic step index width (up to 24 steps)

  // serial multiplier widths
  localparam int MA_W = 34;           // multiplicand, signed
  localparam int MB_W = 25;           // multiplier, signed, up to 25 steps
  localparam int MP_W = MA_W + MB_W;  // product
  localparam int MN_W = 5;            // step count width

  localparam int CV_W = 33;           // cordic x/y width
  localparam int CZ_W = 32;           // cordic angle width

  localparam logic signed [CV_W-1:0] CORDIC_START_X = CV_W'(652032874);

  // reciprocal of ten, 2^23 scale, for the unwrap threshold
  localparam logic [19:0] RECIP_TEN = 20'hCCCCD;

  typedef enum logic [2:0] {
    REG_MODULUS   = 3'd0,
    REG_DIST_GAIN = 3'd1,
    REG_TURN_GAIN = 3'd2,
    REG_START_X   = 3'd3,
    REG_START_Y   = 3'd4,
    REG_START_YAW = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RECIP,
    ST_UNWRAP,
    ST_MYAW,
    ST_MDIST,
    ST_CWAIT,
    ST_MX,
    ST_MY,
    ST_OUT
  } odo_state_t;

  function automatic logic signed [CZ_W-1:0] atan_entry(input logic [CI_W-1:0] i);
    logic signed [CZ_W-1:0] v;
    unique case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

  // round to q1.15 and saturate
  function automatic logic signed [15:0] to_q15(input logic signed [CV_W-1:0] v);
    logic signed [CV_W:0] w;
    logic signed [CV_W-15:0] r;
    logic signed [15:0] o;
    w = {v[CV_W-1], v} + (CV_W+1)'(16384);
    r = w[CV_W:15];
    if (r > (CV_W-14)'(32767)) o = 16'sh7FFF;
    else if (r < -(CV_W-14)'(32768)) o = 16'sh8000;
    else o = r[15:0];
    return o;
  endfunction

  // unwrap one wheel change against the modulus and threshold
  function automatic logic [16:0] unwrap(input logic [15:0] raw, input logic [15:0] prev,
                                         input logic [16:0] m, input logic [13:0] t);
    logic signed [18:0] d;
    logic signed [18:0] ts;
    logic signed [18:0] ms;
    d  = $signed({3'b0, raw}) - $signed({3'b0, prev});
    ts = $signed({5'b0, t});
    ms = $signed({2'b0, m});
    if (d > ts) d = d - ms;
    if (d < -ts) d = d + ms;
    return d[16:0];
  endfunction

endpackage

// ===== rtl/odo_mul.sv =====
// ----------------------------------------------------------------------------
// odo_mul
// shift-add multiplier, one multiplier bit per cycle, top step signed
// ----------------------------------------------------------------------------
module odo_mul import odo_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic signed [MA_W-1:0] a,
  input  logic        [MB_W-1:0] b,
  input  logic        [MN_W-1:0] nbits,
  output logic                   done,
  output logic signed [MP_W-1:0] p
);

  logic signed [MP_W-1:0] mcand;
  logic        [MB_W-1:0] mplier;
  logic        [MN_W-1:0] cnt;
  logic                   run;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && cnt == '0) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      p      <= '0;
      mcand  <= MP_W'(a);
      mplier <= b;
      cnt    <= nbits - MN_W'(1);
    end else if (run) begin
      // last step carries negative weight
      if (mplier[0]) begin
        if (cnt == '0) p <= p - mcand;
        else p <= p + mcand;
      end
      mcand  <= mcand <<< 1;
      mplier <= mplier >> 1;
      cnt    <= cnt - MN_W'(1);
    end
  end

endmodule

// ===== rtl/odo_cordic.sv =====
// ----------------------------------------------------------------------------
// odo_cordic
// iterative rotation cordic, one micro-rotation per cycle, q1.15 cos/sin
// ----------------------------------------------------------------------------
module odo_cordic import odo_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [15:0]        yaw,
  output logic               ready,
  output logic signed [15:0] cos_q,
  output logic signed [15:0] sin_q
);

  logic signed [CV_W-1:0] x;
  logic signed [CV_W-1:0] y;
  logic signed [CZ_W-1:0] z;
  logic [CI_W-1:0]        i;
  logic [1:0]             q;
  logic                   run;
  logic                   fin;
  logic [1:0]             q_in;
  logic [15:0]            r_in;
  logic [15:0]            yaw_off;
  logic signed [CV_W-1:0] c_raw;
  logic signed [CV_W-1:0] s_raw;

  assign yaw_off = yaw + 16'h2000;
  assign q_in    = yaw_off[15:14];
  assign r_in    = yaw - {q_in, 14'b0};
  assign ready   = !run && !fin;

  always_comb begin
    unique case (q)
      2'd0: begin c_raw = x;  s_raw = y;  end
      2'd1: begin c_raw = -y; s_raw = x;  end
      2'd2: begin c_raw = -x; s_raw = -y; end
      default: begin c_raw = y; s_raw = -x; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      fin <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && i == CI_W'(CORDIC_STAGES - 1)) begin
        run <= 1'b0;
        fin <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= CORDIC_START_X;
      y <= '0;
      z <= $signed({r_in, 16'b0});
      q <= q_in;
      i <= '0;
    end else if (run) begin
      if (z >= 0) begin
        x <= x - (y >>> i);
        y <= y + (x >>> i);
        z <= z - atan_entry(i);
      end else begin
        x <= x + (y >>> i);
        y <= y - (x >>> i);
        z <= z + atan_entry(i);
      end
      i <= i + CI_W'(1);
    end
    if (fin) begin
      cos_q <= to_q15(c_raw);
      sin_q <= to_q15(s_raw);
    end
  end

endmodule

// ===== rtl/wheel_encoder_odometry.sv =====
// ----------------------------------------------------------------------------
// wheel_encoder_odometry
// differential-drive wheel odometry with serial multiply and iterative cordic
// ----------------------------------------------------------------------------
// One request is handled at a time. A load-pose request goes straight to the
// output register. An encoder sample first computes the modulus/10
// threshold, then unwraps both wheels, runs the 25-step heading product and
// the 17-step distance product (the 16-step cordic runs alongside it), picks
// up cos/sin, runs the 16-step x and y products, and loads the output
// register. The serial multiplier sets the rate. The result is held in an
// output register until taken; a new request is taken once the previous
// result has been moved into that register.
module wheel_encoder_odometry import odo_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               command,
  input  logic [15:0]        raw_right_count,
  input  logic [15:0]        raw_left_count,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [16:0] delta_right,
  output logic signed [16:0] delta_left,
  output logic signed [31:0] pose_x,
  output logic signed [31:0] pose_y,
  output logic [15:0]        pose_yaw,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  // configuration registers
  logic [16:0]        encoder_modulus;
  logic [15:0]        dist_gain;
  logic [23:0]        turn_gain;
  logic [31:0]        start_x;
  logic [31:0]        start_y;
  logic [15:0]        start_yaw;

  // odometry state
  logic [15:0]        prev_right;
  logic [15:0]        prev_left;
  logic               first_right;
  logic               first_left;
  logic [31:0]        cur_x;
  logic [31:0]        cur_y;
  logic [15:0]        cur_yaw;

  // working registers
  odo_state_t         state;
  odo_state_t         state_next;
  logic               cmd_r;
  logic [15:0]        raw_r;
  logic [15:0]        raw_l;
  logic [13:0]        thresh;
  logic [16:0]        dr;
  logic [16:0]        dl;
  logic signed [33:0] dist_prod;

  // multiplier and cordic hookup
  logic                   mul_start;
  logic signed [MA_W-1:0] mul_a;
  logic [MB_W-1:0]        mul_b;
  logic [MN_W-1:0]        mul_n;
  logic                   mul_done;
  logic signed [MP_W-1:0] mul_p;
  logic                   cor_start;
  logic                   cor_ready;
  logic signed [15:0]     cos_q;
  logic signed [15:0]     sin_q;

  logic [36:0]            recip_prod;
  logic [16:0]            dr_new;
  logic [16:0]            dl_new;
  logic [MP_W-1:0]        yaw_round;
  logic [MP_W-1:0]        pos_round;
  logic [15:0]            yaw_new;
  logic                   in_fire;

  assign cfg_ready  = 1'b1;
  assign in_ready   = (state == ST_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign recip_prod = 37'(encoder_modulus) * 37'(RECIP_TEN);
  assign dr_new     = first_right ? 17'd0 : unwrap(raw_r, prev_right, encoder_modulus, thresh);
  assign dl_new     = first_left  ? 17'd0 : unwrap(raw_l, prev_left, encoder_modulus, thresh);
  assign yaw_round  = mul_p + MP_W'(32768);
  assign pos_round  = mul_p + MP_W'(1 << 23);
  assign yaw_new    = cur_yaw + yaw_round[31:16];

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      encoder_modulus <= 17'd65535;
      dist_gain       <= 16'd7466;
      turn_gain       <= 24'd1179648;
      start_x         <= '0;
      start_y         <= '0;
      start_yaw       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODULUS:   encoder_modulus <= cfg_data[16:0];
        REG_DIST_GAIN: dist_gain       <= cfg_data[15:0];
        REG_TURN_GAIN: turn_gain       <= cfg_data[23:0];
        REG_START_X:   start_x         <= cfg_data;
        REG_START_Y:   start_y         <= cfg_data;
        REG_START_YAW: start_yaw       <= cfg_data[15:0];
        default: ; // unknown index ignored
      endcase
    end
  end

  // sequencer next state and unit launches
  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    mul_n      = '0;
    cor_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) state_next = command ? ST_OUT : ST_RECIP;
      end
      ST_RECIP: state_next = ST_UNWRAP;
      ST_UNWRAP: begin
        // heading product: (left - right) times turn gain
        mul_start  = 1'b1;
        mul_a      = MA_W'($signed(dl_new)) - MA_W'($signed(dr_new));
        mul_b      = {1'b0, turn_gain};
        mul_n      = MN_W'(25);
        state_next = ST_MYAW;
      end
      ST_MYAW: begin
        if (mul_done) begin
          // distance product and cordic of the new heading in parallel
          mul_start  = 1'b1;
          mul_a      = MA_W'($signed(dr)) + MA_W'($signed(dl));
          mul_b      = MB_W'(dist_gain);
          mul_n      = MN_W'(17);
          cor_start  = 1'b1;
          state_next = ST_MDIST;
        end
      end
      ST_MDIST: if (mul_done) state_next = ST_CWAIT;
      ST_CWAIT: begin
        if (cor_ready) begin
          mul_start  = 1'b1;
          mul_a      = dist_prod;
          mul_b      = MB_W'(cos_q);
          mul_n      = MN_W'(16);
          state_next = ST_MX;
        end
      end
      ST_MX: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_a      = dist_prod;
          mul_b      = MB_W'(sin_q);
          mul_n      = MN_W'(16);
          state_next = ST_MY;
        end
      end
      ST_MY: if (mul_done) state_next = ST_OUT;
      ST_OUT: if (!out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // odometry state and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_right  <= '0;
      prev_left   <= '0;
      first_right <= 1'b1;
      first_left  <= 1'b1;
      cur_x       <= '0;
      cur_y       <= '0;
      cur_yaw     <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_fire && command) begin
            cur_x   <= start_x;
            cur_y   <= start_y;
            cur_yaw <= start_yaw;
          end
        end
        ST_UNWRAP: begin
          prev_right  <= raw_r;
          prev_left   <= raw_l;
          first_right <= 1'b0;
          first_left  <= 1'b0;
        end
        ST_MYAW: if (mul_done) cur_yaw <= yaw_new;
        ST_MX:   if (mul_done) cur_x <= cur_x + pos_round[55:24];
        ST_MY:   if (mul_done) cur_y <= cur_y + pos_round[55:24];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= command;
      raw_r <= raw_right_count;
      raw_l <= raw_left_count;
    end
    if (state == ST_RECIP) thresh <= recip_prod[36:23];
    if (state == ST_UNWRAP) begin
      dr <= dr_new;
      dl <= dl_new;
    end
    if (state == ST_MDIST && mul_done) dist_prod <= mul_p[33:0];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!out_valid || out_ready)) begin
      // load-pose requests report zero deltas
      delta_right <= cmd_r ? 17'sd0 : $signed(dr);
      delta_left  <= cmd_r ? 17'sd0 : $signed(dl);
      pose_x      <= $signed(cur_x);
      pose_y      <= $signed(cur_y);
      pose_yaw    <= cur_yaw;
    end
  end

  odo_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .nbits (mul_n),
    .done  (mul_done),
    .p     (mul_p)
  );

  odo_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .yaw   (yaw_new),
    .ready (cor_ready),
    .cos_q (cos_q),
    .sin_q (sin_q)
  );

endmodule

// ===== tb/wheel_encoder_odometry_tb.sv =====
// ----------------------------------------------------------------------------
// wheel_encoder_odometry_tb
// self-checking bench: directed table then random encoder traffic per setting
// ----------------------------------------------------------------------------
// Every accepted request runs through a local pose tracker (unwrap, heading
// update, cordic sin/cos, position update). The expected results wait in a
// queue until the block returns them, and each one is compared field by
// field. Several register settings, with their extremes, are covered, and
// both channels idle and stall at random.
module wheel_encoder_odometry_tb import odo_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REG_UNUSED = 3'd6;   // no register at this index
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;
  localparam int IDLE_LIMIT   = 20000;        // cycles with no handshake at all
  localparam int DRAIN_CYCLES = 120;          // extra wait after the queue empties

  typedef struct packed {
    logic signed [16:0] dr;
    logic signed [16:0] dl;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [15:0]        yaw;
  } pose_rec_t;

  typedef struct {
    logic        cmd;
    logic [15:0] r;
    logic [15:0] l;
    bit          typed;
    pose_rec_t   res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_ready;
  logic command = 1'b0;
  logic [15:0] raw_right_count = '0, raw_left_count = '0;
  logic out_valid, out_ready = 1'b0;
  logic signed [16:0] delta_right, delta_left;
  logic signed [31:0] pose_x, pose_y;
  logic [15:0] pose_yaw;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // typed expectation travels with the request, driven like the payload
  logic typed_chk = 1'b0;
  pose_rec_t typed_res = '0;

  // tracker copy of the registers and the odometry state
  logic [16:0] wheel_mod;
  logic [15:0] dist_k;
  logic [23:0] turn_k;
  logic [31:0] home_x, home_y;
  logic [15:0] home_yaw;
  logic [15:0] last_r, last_l;
  bit          fresh_r, fresh_l;
  logic [31:0] track_x, track_y;
  logic [15:0] track_yaw;

  pose_rec_t pending_poses[$];
  int errors = 0;
  int n_req = 0, n_res = 0, n_load = 0, n_cfg = 0;
  int idle_pct = 0, stall_pct = 0;
  int quiet = 0;

  wheel_encoder_odometry dut (.*);

  always #2 clk = ~clk;

  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  // ---------------------------------------------------------------- tracker
  function automatic logic [16:0] unwrap_count(logic [15:0] raw, logic [15:0] prev, bit first);
    longint m, t, d;
    m = wheel_mod;
    t = m / 10;
    if (first) return '0;
    d = longint'(raw) - longint'(prev);
    if (d > t) d -= m;
    if (d < -t) d += m;
    return d[16:0];
  endfunction

  function automatic longint round_q15(longint v);
    longint r;
    r = (v + (64'sd1 <<< 14)) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  task automatic heading_cos_sin(input logic [15:0] yaw, output longint c, output longint s);
    logic [1:0] quad;
    logic [15:0] resid;
    longint x, y, z, nx;
    quad = 2'((32'(yaw) + 32'h2000) >> 14);
    resid = yaw - 16'(quad) * 16'h4000;
    x = 652032874;
    y = 0;
    z = longint'($signed(resid)) * 65536;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= longint'(atan_entry(i[CI_W-1:0]));
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += longint'(atan_entry(i[CI_W-1:0]));
      end
      x = nx;
    end
    case (quad)
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    c = round_q15(c);
    s = round_q15(s);
  endtask

  task automatic advance_pose(input logic cmd, input logic [15:0] r, input logic [15:0] l,
                              output pose_rec_t res);
    logic [16:0] dr, dl;
    longint dyaw, travel, c, s;
    dr = '0;
    dl = '0;
    if (cmd == CMD_LOAD) begin
      track_x = home_x;
      track_y = home_y;
      track_yaw = home_yaw;
    end else begin
      dr = unwrap_count(r, last_r, fresh_r);
      dl = unwrap_count(l, last_l, fresh_l);
      last_r = r;
      last_l = l;
      fresh_r = 0;
      fresh_l = 0;
      // heading turns opposite to right-minus-left
      dyaw = (-(longint'($signed(dr)) - longint'($signed(dl))) * longint'(turn_k) + 32768) >>> 16;
      track_yaw = track_yaw + dyaw[15:0];
      heading_cos_sin(track_yaw, c, s);
      travel = (longint'($signed(dr)) + longint'($signed(dl))) * longint'(dist_k);
      track_x = track_x + 32'((travel * c + (64'sd1 <<< 23)) >>> 24);
      track_y = track_y + 32'((travel * s + (64'sd1 <<< 23)) >>> 24);
    end
    res = '{dr: dr, dl: dl, x: track_x, y: track_y, yaw: track_yaw};
  endtask

  // ---------------------------------------------------------------- monitor
  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    pose_rec_t res, want;
    if (rst) begin
      wheel_mod = 17'd65535;
      dist_k = 16'd7466;
      turn_k = 24'd1179648;
      home_x = '0;
      home_y = '0;
      home_yaw = '0;
      last_r = '0;
      last_l = '0;
      fresh_r = 1;
      fresh_l = 1;
      track_x = '0;
      track_y = '0;
      track_yaw = '0;
      quiet = 0;
    end else begin
      quiet++;
      if (cfg_valid && cfg_ready) begin
        quiet = 0;
        n_cfg++;
        case (cfg_index)
          REG_MODULUS:   wheel_mod = cfg_data[16:0];
          REG_DIST_GAIN: dist_k = cfg_data[15:0];
          REG_TURN_GAIN: turn_k = cfg_data[23:0];
          REG_START_X:   home_x = cfg_data;
          REG_START_Y:   home_y = cfg_data;
          REG_START_YAW: home_yaw = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        quiet = 0;
        n_req++;
        if (command == CMD_LOAD) n_load++;
        advance_pose(command, raw_right_count, raw_left_count, res);
        pending_poses.push_back(typed_chk ? typed_res : res);
      end
      if (out_valid && out_ready) begin
        quiet = 0;
        n_res++;
        if (pending_poses.size() == 0) begin
          errors++;
          $display("%0t ns: result with no request waiting", $time);
        end else begin
          want = pending_poses.pop_front();
          check_field("delta_right", want.dr, delta_right);
          check_field("delta_left", want.dl, delta_left);
          check_field("pose_x", want.x, pose_x);
          check_field("pose_y", want.y, pose_y);
          check_field("pose_yaw", want.yaw, pose_yaw);
        end
      end
      if (quiet >= IDLE_LIMIT) begin
        $display("%0t ns: watchdog, no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("wheel_encoder_odometry test failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- drivers
  task automatic send_request(logic cmd, logic [15:0] r, logic [15:0] l,
                              bit typed = 0, pose_rec_t res = '0);
    in_valid <= 1'b1;
    command <= cmd;
    raw_right_count <= r;
    raw_left_count <= l;
    typed_chk <= typed;
    typed_res <= res;
    do @(posedge clk); while (!in_ready);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // let everything in flight come back before touching registers
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_poses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- stimulus
  dir_row_t dir_rows[$];
  logic [15:0] gen_r, gen_l;
  logic [16:0] mod_pick[6] = '{17'd65536, 17'd1, 17'd0, 17'd131071, 17'd10, 17'd4096};

  function automatic logic [15:0] next_count(logic [15:0] cur, int th);
    int k;
    k = $urandom_range(99);
    if (k < 60) return cur + 16'($urandom_range(0, 80)) - 16'd40;   // normal motion
    if (k < 80) return cur + 16'(th) + 16'($urandom_range(0, 2)) - 16'd1; // near threshold
    if (k < 90) return cur - 16'(th) + 16'($urandom_range(0, 2)) - 16'd1;
    return 16'($urandom());                                          // glitch
  endfunction

  initial begin
    pose_rec_t zero_pose;
    int th;
    zero_pose = '0;
    // directed: first sample, load pose, count extremes, threshold edges
    dir_rows.push_back('{CMD_SAMPLE, 16'd1234, 16'd4321, 1, zero_pose});
    dir_rows.push_back('{CMD_LOAD, 16'hFFFF, 16'hAAAA, 1, zero_pose});
    dir_rows.push_back('{CMD_SAMPLE, 16'd0, 16'd0, 0, zero_pose});
    dir_rows.push_back('{CMD_SAMPLE, 16'd65535, 16'd65535, 0, zero_pose});
    dir_rows.push_back('{CMD_SAMPLE, 16'd0, 16'd65535, 0, zero_pose});
    dir_rows.push_back('{CMD_SAMPLE, 16'd6553, 16'd0, 0, zero_pose});
    dir_rows.push_back('{CMD_SAMPLE, 16'd13107, 16'd6553, 0, zero_pose});
    dir_rows.push_back('{CMD_SAMPLE, 16'd6553, 16'd13107, 0, zero_pose});
    dir_rows.push_back('{CMD_SAMPLE, 16'd6552, 16'd13108, 0, zero_pose});
    dir_rows.push_back('{CMD_SAMPLE, 16'h5555, 16'hAAAA, 0, zero_pose});
    dir_rows.push_back('{CMD_SAMPLE, 16'hAAAA, 16'h5555, 0, zero_pose});
    dir_rows.push_back('{CMD_SAMPLE, 16'hAA00, 16'h55FF, 0, zero_pose});
    dir_rows.push_back('{CMD_SAMPLE, 16'hAB00, 16'h54FF, 0, zero_pose});
    dir_rows.push_back('{CMD_LOAD, 16'd0, 16'd0, 1, zero_pose});
    dir_rows.push_back('{CMD_SAMPLE, 16'hAB40, 16'h54C0, 0, zero_pose});

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      send_request(dir_rows[i].cmd, dir_rows[i].r, dir_rows[i].l,
                   dir_rows[i].typed, dir_rows[i].res);
    drain();

    // unknown register index must change nothing
    write_reg(REG_UNUSED, 32'h0000_0007);
    typed_chk <= 1'b0;
    gen_r = 16'hAB40;
    gen_l = 16'h54C0;

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 65; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 65; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      write_reg(REG_MODULUS, (ph < 6) ? 32'(mod_pick[ph]) : $urandom_range(100, 65536));
      write_reg(REG_DIST_GAIN, (ph == 1) ? 32'd0 : (ph == 2) ? 32'd65535 : $urandom());
      write_reg(REG_TURN_GAIN, (ph == 2) ? 32'd0 : (ph == 3) ? 32'hFFFFFF : $urandom());
      write_reg(REG_START_X, (ph == 4) ? 32'h8000_0000 : (ph == 5) ? 32'h7FFF_FFFF : $urandom());
      write_reg(REG_START_Y, (ph == 4) ? 32'h7FFF_FFFF : (ph == 5) ? 32'h8000_0000 : $urandom());
      write_reg(REG_START_YAW, (ph == 4) ? 32'd65535 : (ph == 5) ? 32'd0 : $urandom());
      th = int'(wheel_mod) / 10;
      for (int n = 0; n < 86; n++) begin
        // hold off until the block is empty once mid-run
        if (ph == 3 && n == 40) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending_poses.size() != 0) @(posedge clk);
        end
        if ($urandom_range(99) < 8) begin
          send_request(CMD_LOAD, 16'($urandom()), 16'($urandom()));
        end else begin
          gen_r = next_count(gen_r, th);
          gen_l = ($urandom_range(3) == 0) ? next_count(gen_l, th)
                                          : gen_l + (gen_r - gen_l) / 16'd512 + 16'd3;
          send_request(CMD_SAMPLE, gen_r, gen_l);
        end
      end
      drain();
    end

    $display("covered %0d requests (%0d pose loads), %0d results, %0d register writes",
             n_req, n_load, n_res, n_cfg);
    $display("eight register settings including modulus 0, 1, 65536 and 131071");
    if (errors == 0 && pending_poses.size() == 0) begin
      $display("wheel_encoder_odometry test passed");
    end else begin
      $display("wheel_encoder_odometry test failed");
    end
    $finish;
  end

endmodule
